### rtl/c8alu_pkg.sv
package c8alu_pkg;

  // Operation codes as they arrive on the request channel.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBC  = 5'd3,
    OP_AND  = 5'd4,
    OP_XOR  = 5'd5,
    OP_OR   = 5'd6,
    OP_CP   = 5'd7,
    OP_INC  = 5'd8,
    OP_DEC  = 5'd9,
    OP_RLCA = 5'd10,
    OP_RLA  = 5'd11,
    OP_RRCA = 5'd12,
    OP_RRA  = 5'd13,
    OP_RLC  = 5'd14,
    OP_RL   = 5'd15,
    OP_RRC  = 5'd16,
    OP_RR   = 5'd17,
    OP_BIT  = 5'd18,
    OP_CPL  = 5'd19,
    OP_SCF  = 5'd20,
    OP_CCF  = 5'd21
  } op_t;

  // Operation class after decode.
  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_AND, K_XOR, K_OR, K_INC, K_DEC,
    K_ROT, K_BIT, K_CPL, K_SCF, K_CCF, K_PASS
  } kind_t;

  // Rotate flavor: left circular, left through carry, right circular,
  // right through carry.
  typedef enum logic [1:0] {
    ROT_LC, ROT_L, ROT_RC, ROT_R
  } rot_t;

  // Flag positions in the flag byte.
  localparam int FLAG_Z_BIT = 7;
  localparam int FLAG_N_BIT = 6;
  localparam int FLAG_H_BIT = 5;
  localparam int FLAG_C_BIT = 4;

  // Decoded control carried from the decode stage to the execute stage.
  typedef struct packed {
    kind_t      kind;
    logic       use_cin;
    logic       rot_b;
    rot_t       rot;
    logic       rot_z;
    logic       keep_acc;
  } dec_t;

  // Operands and incoming flags carried with the decoded control.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] opd;
    logic [2:0] idx;
    logic       z_in;
    logic       n_in;
    logic       h_in;
    logic       c_in;
  } opnd_t;

  // Execute stage output: result byte and flags, with zero detect deferred.
  typedef struct packed {
    logic [7:0] res;
    logic       z_use_res;
    logic       z_fix;
    logic       n;
    logic       h;
    logic       c;
  } ex_t;

endpackage

### rtl/cpu8_alu_with_flags_top.sv
// 8-bit processor ALU with Z/N/H/C flags in a three-stage pipeline (decode,
// execute, flag pack and output register). It accepts one request every
// clock cycle while the result side does not stall, and each result passes
// through the decode, execute and output registers in turn. Every stage
// carries a valid bit and advances when it is empty or the stage after it
// advances, so a stall on the result side fills the bubbles first and then
// holds the request side, with nothing lost or repeated. Flag bytes use bit
// 7 Z, bit 6 N, bit 5 H and bit 4 C; the low nibble of flags_out is always
// zero and that of flags_in is ignored.
module cpu8_alu_with_flags_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_operation,
  input  logic [7:0]  in_acc_value,
  input  logic [7:0]  in_operand,
  input  logic [2:0]  in_bit_index,
  input  logic [7:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_result,
  output logic [7:0]  out_flags_out
);
  import c8alu_pkg::*;

  logic  dec_valid;
  logic  ex_valid;
  logic  adv_dec;
  logic  adv_ex;
  logic  adv_out;
  dec_t  dec;
  opnd_t opnd;
  ex_t   ex;

  // Each stage moves when it is empty or the next one moves.
  always_comb begin
    adv_out  = !out_valid || !out_stall;
    adv_ex   = !ex_valid || adv_out;
    adv_dec  = !dec_valid || adv_ex;
    in_stall = !adv_dec;
  end

  c8alu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv_dec),
    .in_valid  (in_valid),
    .operation (in_operation),
    .acc_value (in_acc_value),
    .operand   (in_operand),
    .bit_index (in_bit_index),
    .flags_in  (in_flags_in),
    .valid_r   (dec_valid),
    .dec_r     (dec),
    .opnd_r    (opnd)
  );

  c8alu_exec u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv_ex),
    .valid   (dec_valid),
    .dec     (dec),
    .opnd    (opnd),
    .valid_r (ex_valid),
    .ex_r    (ex)
  );

  c8alu_flags u_flags (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv_out),
    .valid    (ex_valid),
    .ex       (ex),
    .valid_r  (out_valid),
    .result_r (out_result),
    .flags_r  (out_flags_out)
  );

endmodule

### rtl/c8alu_decode.sv
module c8alu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [4:0]        operation,
  input  logic [7:0]        acc_value,
  input  logic [7:0]        operand,
  input  logic [2:0]        bit_index,
  input  logic [7:0]        flags_in,
  output logic              valid_r,
  output c8alu_pkg::dec_t   dec_r,
  output c8alu_pkg::opnd_t  opnd_r
);
  import c8alu_pkg::*;

  dec_t  dec_nxt;
  opnd_t opnd_nxt;

  // Map the operation code onto a class and its modifiers.
  always_comb begin
    dec_nxt.kind     = K_PASS;
    dec_nxt.use_cin  = 1'b0;
    dec_nxt.rot_b    = 1'b0;
    dec_nxt.rot      = ROT_LC;
    dec_nxt.rot_z    = 1'b0;
    dec_nxt.keep_acc = 1'b0;
    case (op_t'(operation))
      OP_ADD: begin
        dec_nxt.kind = K_ADD;
      end
      OP_ADC: begin
        dec_nxt.kind    = K_ADD;
        dec_nxt.use_cin = 1'b1;
      end
      OP_SUB: begin
        dec_nxt.kind = K_SUB;
      end
      OP_SBC: begin
        dec_nxt.kind    = K_SUB;
        dec_nxt.use_cin = 1'b1;
      end
      OP_CP: begin
        dec_nxt.kind     = K_SUB;
        dec_nxt.keep_acc = 1'b1;
      end
      OP_AND: dec_nxt.kind = K_AND;
      OP_XOR: dec_nxt.kind = K_XOR;
      OP_OR:  dec_nxt.kind = K_OR;
      OP_INC: dec_nxt.kind = K_INC;
      OP_DEC: dec_nxt.kind = K_DEC;
      OP_RLCA: begin
        dec_nxt.kind = K_ROT;
        dec_nxt.rot  = ROT_LC;
      end
      OP_RLA: begin
        dec_nxt.kind = K_ROT;
        dec_nxt.rot  = ROT_L;
      end
      OP_RRCA: begin
        dec_nxt.kind = K_ROT;
        dec_nxt.rot  = ROT_RC;
      end
      OP_RRA: begin
        dec_nxt.kind = K_ROT;
        dec_nxt.rot  = ROT_R;
      end
      OP_RLC: begin
        dec_nxt.kind  = K_ROT;
        dec_nxt.rot   = ROT_LC;
        dec_nxt.rot_b = 1'b1;
        dec_nxt.rot_z = 1'b1;
      end
      OP_RL: begin
        dec_nxt.kind  = K_ROT;
        dec_nxt.rot   = ROT_L;
        dec_nxt.rot_b = 1'b1;
        dec_nxt.rot_z = 1'b1;
      end
      OP_RRC: begin
        dec_nxt.kind  = K_ROT;
        dec_nxt.rot   = ROT_RC;
        dec_nxt.rot_b = 1'b1;
        dec_nxt.rot_z = 1'b1;
      end
      OP_RR: begin
        dec_nxt.kind  = K_ROT;
        dec_nxt.rot   = ROT_R;
        dec_nxt.rot_b = 1'b1;
        dec_nxt.rot_z = 1'b1;
      end
      OP_BIT: dec_nxt.kind = K_BIT;
      OP_CPL: dec_nxt.kind = K_CPL;
      OP_SCF: dec_nxt.kind = K_SCF;
      OP_CCF: dec_nxt.kind = K_CCF;
      default: dec_nxt.kind = K_PASS;
    endcase
  end

  // Split out the incoming flag bits; the low nibble is dropped.
  always_comb begin
    opnd_nxt.acc  = acc_value;
    opnd_nxt.opd  = operand;
    opnd_nxt.idx  = bit_index;
    opnd_nxt.z_in = flags_in[FLAG_Z_BIT];
    opnd_nxt.n_in = flags_in[FLAG_N_BIT];
    opnd_nxt.h_in = flags_in[FLAG_H_BIT];
    opnd_nxt.c_in = flags_in[FLAG_C_BIT];
  end

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
    if (adv) begin
      dec_r  <= dec_nxt;
      opnd_r <= opnd_nxt;
    end
  end

endmodule

### rtl/c8alu_exec.sv
module c8alu_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              valid,
  input  c8alu_pkg::dec_t   dec,
  input  c8alu_pkg::opnd_t  opnd,
  output logic              valid_r,
  output c8alu_pkg::ex_t    ex_r
);
  import c8alu_pkg::*;

  logic       cin;
  logic [8:0] sum9;
  logic [8:0] dif9;
  logic [4:0] sumh;
  logic [4:0] difh;
  logic [7:0] rot_v;
  logic [7:0] rot_res;
  logic       rot_out;
  ex_t        ex_nxt;

  // Adder and subtractor share the carry-in; the nibble sums give H.
  always_comb begin
    cin  = dec.use_cin & opnd.c_in;
    sum9 = {1'b0, opnd.acc} + {1'b0, opnd.opd} + {8'd0, cin};
    dif9 = {1'b0, opnd.acc} - {1'b0, opnd.opd} - {8'd0, cin};
    sumh = {1'b0, opnd.acc[3:0]} + {1'b0, opnd.opd[3:0]} + {4'd0, cin};
    difh = {1'b0, opnd.acc[3:0]} - {1'b0, opnd.opd[3:0]} - {4'd0, cin};
  end

  // Rotator for both the accumulator and the prefixed forms.
  always_comb begin
    rot_v = dec.rot_b ? opnd.opd : opnd.acc;
    case (dec.rot)
      ROT_LC: begin
        rot_res = {rot_v[6:0], rot_v[7]};
        rot_out = rot_v[7];
      end
      ROT_L: begin
        rot_res = {rot_v[6:0], opnd.c_in};
        rot_out = rot_v[7];
      end
      ROT_RC: begin
        rot_res = {rot_v[0], rot_v[7:1]};
        rot_out = rot_v[0];
      end
      ROT_R: begin
        rot_res = {opnd.c_in, rot_v[7:1]};
        rot_out = rot_v[0];
      end
      default: begin
        rot_res = rot_v;
        rot_out = 1'b0;
      end
    endcase
  end

  // Result select and flags other than the zero detect on the result.
  always_comb begin
    ex_nxt.res       = opnd.acc;
    ex_nxt.z_use_res = 1'b0;
    ex_nxt.z_fix     = opnd.z_in;
    ex_nxt.n         = 1'b0;
    ex_nxt.h         = 1'b0;
    ex_nxt.c         = opnd.c_in;
    case (dec.kind)
      K_ADD: begin
        ex_nxt.res       = sum9[7:0];
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.h         = sumh[4];
        ex_nxt.c         = sum9[8];
      end
      K_SUB: begin
        // Compare keeps the accumulator but flags the difference.
        ex_nxt.res   = dec.keep_acc ? opnd.acc : dif9[7:0];
        ex_nxt.z_fix = ~|dif9[7:0];
        ex_nxt.n     = 1'b1;
        ex_nxt.h     = difh[4];
        ex_nxt.c     = dif9[8];
      end
      K_AND: begin
        ex_nxt.res       = opnd.acc & opnd.opd;
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.h         = 1'b1;
        ex_nxt.c         = 1'b0;
      end
      K_XOR: begin
        ex_nxt.res       = opnd.acc ^ opnd.opd;
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.c         = 1'b0;
      end
      K_OR: begin
        ex_nxt.res       = opnd.acc | opnd.opd;
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.c         = 1'b0;
      end
      K_INC: begin
        ex_nxt.res       = opnd.opd + 8'd1;
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.h         = &opnd.opd[3:0];
      end
      K_DEC: begin
        ex_nxt.res       = opnd.opd - 8'd1;
        ex_nxt.z_use_res = 1'b1;
        ex_nxt.n         = 1'b1;
        ex_nxt.h         = ~|opnd.opd[3:0];
      end
      K_ROT: begin
        // Accumulator rotates always clear Z.
        ex_nxt.res       = rot_res;
        ex_nxt.z_use_res = dec.rot_z;
        ex_nxt.z_fix     = 1'b0;
        ex_nxt.c         = rot_out;
      end
      K_BIT: begin
        ex_nxt.res   = opnd.opd;
        ex_nxt.z_fix = ~opnd.opd[opnd.idx];
        ex_nxt.h     = 1'b1;
      end
      K_CPL: begin
        ex_nxt.res = ~opnd.acc;
        ex_nxt.n   = 1'b1;
        ex_nxt.h   = 1'b1;
      end
      K_SCF: begin
        ex_nxt.c = 1'b1;
      end
      K_CCF: begin
        ex_nxt.c = ~opnd.c_in;
      end
      K_PASS: begin
        // Unused codes hand the incoming flags through.
        ex_nxt.n = opnd.n_in;
        ex_nxt.h = opnd.h_in;
      end
      default: begin
        ex_nxt.n = opnd.n_in;
        ex_nxt.h = opnd.h_in;
      end
    endcase
  end

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid;
    end
    if (adv) begin
      ex_r <= ex_nxt;
    end
  end

endmodule

### rtl/c8alu_flags.sv
module c8alu_flags (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            valid,
  input  c8alu_pkg::ex_t  ex,
  output logic            valid_r,
  output logic [7:0]      result_r,
  output logic [7:0]      flags_r
);
  import c8alu_pkg::*;

  logic       z;
  logic [7:0] flags_nxt;

  // Zero detect on the result, then pack the flag byte.
  always_comb begin
    z         = ex.z_use_res ? ~|ex.res : ex.z_fix;
    flags_nxt = 8'd0;
    flags_nxt[FLAG_Z_BIT] = z;
    flags_nxt[FLAG_N_BIT] = ex.n;
    flags_nxt[FLAG_H_BIT] = ex.h;
    flags_nxt[FLAG_C_BIT] = ex.c;
  end

  // Output register; it holds while the result side stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid;
    end
    if (adv) begin
      result_r <= ex.res;
      flags_r  <= flags_nxt;
    end
  end

endmodule

### rtl/c8alu_checker.sv
module c8alu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [4:0]  in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_result,
  input logic [7:0]  out_flags_out
);
  import c8alu_pkg::*;

  // A result held by a stall stays offered.
  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result) && $stable(out_flags_out))
    else $error("stalled result changed");

  // With the result side free, the pipeline never pushes back.
  a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("request side stalled with result side free");

  // An accepted request reaches the output if the result side does not stall meanwhile.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted request did not reach the output");

  // Set carry shows C set and N clear on its result when the result side does not stall.
  a_scf_carry: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_SCF ##1 !out_stall ##1 !out_stall
    |=> out_flags_out[FLAG_C_BIT] && out_flags_out[FLAG_N_BIT] == 1'b0)
    else $error("set carry result has wrong flags");

endmodule

bind cpu8_alu_with_flags_top c8alu_checker u_c8alu_checker (.*);

### bench/tb_cpu8_alu_with_flags_top.sv
`timescale 1ns / 100ps

module tb_cpu8_alu_with_flags_top;
  import c8alu_pkg::*;

  localparam int RANDOM_REQUESTS = 1100;
  localparam int CYCLE_LIMIT     = 250000;
  localparam int DRAIN_CYCLES    = 10;

  // Expected result byte and flag byte of one request.
  typedef struct {
    logic [7:0] result;
    logic [7:0] flags;
  } alu_outcome_t;

  // Keeps the outcomes of accepted requests in order and compares them with
  // what the block returns.
  class alu_scoreboard;
    alu_outcome_t pending_results[$];
    int errors;
    int checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    // Works out the result byte and flags of one operation.
    function void compute_alu(input logic [4:0] op, input logic [7:0] a,
                              input logic [7:0] b, input logic [2:0] idx,
                              input logic [7:0] fin, output logic [7:0] res,
                              output logic [7:0] fl);
      logic       cin;
      logic       carry_used;
      logic       shifted_out;
      logic [8:0] wide;
      logic [4:0] nib;
      logic [7:0] v;
      cin = fin[FLAG_C_BIT];
      res = a;
      fl  = fin & 8'hF0;
      case (op)
        OP_ADD, OP_ADC: begin
          carry_used = (op == OP_ADC) ? cin : 1'b0;
          wide = {1'b0, a} + {1'b0, b} + {8'd0, carry_used};
          nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_used};
          res  = wide[7:0];
          fl   = 8'h00;
          fl[FLAG_Z_BIT] = (res == 8'h00);
          fl[FLAG_H_BIT] = nib[4];
          fl[FLAG_C_BIT] = wide[8];
        end
        OP_SUB, OP_SBC, OP_CP: begin
          carry_used = (op == OP_SBC) ? cin : 1'b0;
          wide = {1'b0, a} - {1'b0, b} - {8'd0, carry_used};
          nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_used};
          // Compare leaves the accumulator as the result.
          res  = (op == OP_CP) ? a : wide[7:0];
          fl   = 8'h00;
          fl[FLAG_Z_BIT] = (wide[7:0] == 8'h00);
          fl[FLAG_N_BIT] = 1'b1;
          fl[FLAG_H_BIT] = nib[4];
          fl[FLAG_C_BIT] = wide[8];
        end
        OP_AND, OP_XOR, OP_OR: begin
          if (op == OP_AND) res = a & b;
          else if (op == OP_XOR) res = a ^ b;
          else res = a | b;
          fl = 8'h00;
          fl[FLAG_Z_BIT] = (res == 8'h00);
          fl[FLAG_H_BIT] = (op == OP_AND);
        end
        OP_INC, OP_DEC: begin
          res = (op == OP_INC) ? b + 8'd1 : b - 8'd1;
          fl  = 8'h00;
          fl[FLAG_Z_BIT] = (res == 8'h00);
          fl[FLAG_N_BIT] = (op == OP_DEC);
          fl[FLAG_H_BIT] = (op == OP_INC) ? (b[3:0] == 4'hF) : (b[3:0] == 4'h0);
          fl[FLAG_C_BIT] = cin;
        end
        OP_RLCA, OP_RLA, OP_RRCA, OP_RRA, OP_RLC, OP_RL, OP_RRC, OP_RR: begin
          v = (op <= OP_RRA) ? a : b;
          case (op)
            OP_RLCA, OP_RLC: begin
              shifted_out = v[7];
              res = {v[6:0], v[7]};
            end
            OP_RLA, OP_RL: begin
              shifted_out = v[7];
              res = {v[6:0], cin};
            end
            OP_RRCA, OP_RRC: begin
              shifted_out = v[0];
              res = {v[0], v[7:1]};
            end
            default: begin
              shifted_out = v[0];
              res = {cin, v[7:1]};
            end
          endcase
          fl = 8'h00;
          fl[FLAG_C_BIT] = shifted_out;
          // Only the prefixed rotates report a zero result.
          fl[FLAG_Z_BIT] = (op >= OP_RLC) && (res == 8'h00);
        end
        OP_BIT: begin
          res = b;
          fl  = 8'h00;
          fl[FLAG_Z_BIT] = ~b[idx];
          fl[FLAG_H_BIT] = 1'b1;
          fl[FLAG_C_BIT] = cin;
        end
        OP_CPL: begin
          res = ~a;
          fl[FLAG_N_BIT] = 1'b1;
          fl[FLAG_H_BIT] = 1'b1;
        end
        OP_SCF, OP_CCF: begin
          fl[FLAG_N_BIT] = 1'b0;
          fl[FLAG_H_BIT] = 1'b0;
          fl[FLAG_C_BIT] = (op == OP_SCF) ? 1'b1 : ~cin;
        end
        default: begin
          // Unused codes pass the accumulator and the upper flag nibble.
          res = a;
        end
      endcase
    endfunction

    function void note_request(input logic [4:0] op, input logic [7:0] a,
                               input logic [7:0] b, input logic [2:0] idx,
                               input logic [7:0] fin);
      alu_outcome_t outcome;
      compute_alu(op, a, b, idx, fin, outcome.result, outcome.flags);
      pending_results.push_back(outcome);
    endfunction

    function void check_result(input logic [7:0] res, input logic [7:0] fl);
      alu_outcome_t outcome;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %02h flags %02h", $time, res, fl);
        errors++;
        return;
      end
      outcome = pending_results.pop_front();
      checked++;
      if (res !== outcome.result) begin
        $display("%0t: result mismatch, expected %02h, actual %02h",
                 $time, outcome.result, res);
        errors++;
      end
      if (fl !== outcome.flags) begin
        $display("%0t: flags mismatch, expected %02h, actual %02h",
                 $time, outcome.flags, fl);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [4:0] in_operation = 5'd0;
  logic [7:0] in_acc_value = 8'h00;
  logic [7:0] in_operand = 8'h00;
  logic [2:0] in_bit_index = 3'd0;
  logic [7:0] in_flags_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_result;
  logic [7:0] out_flags_out;

  alu_scoreboard sb = new();
  int  cycle_count = 0;
  int  requests_sent = 0;
  bit  quiet = 1'b0;

  cpu8_alu_with_flags_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_acc_value  (in_acc_value),
    .in_operand    (in_operand),
    .in_bit_index  (in_bit_index),
    .in_flags_in   (in_flags_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_flags_out (out_flags_out)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle cycles for one request or one result; none during quiet stretches.
  function automatic int draw_wait();
    if (quiet) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Bytes leaning toward the values where carries and zero flags change.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: begin
        case ($urandom_range(0, 5))
          0: return 8'h0F;
          1: return 8'hF0;
          2: return 8'h7F;
          3: return 8'h80;
          4: return 8'h10;
          default: return 8'h01;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one request after a random gap and waits until it is taken.
  task automatic drive_request(input logic [4:0] op, input logic [7:0] a,
                               input logic [7:0] b, input logic [2:0] idx,
                               input logic [7:0] fin);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_acc_value <= a;
    in_operand   <= b;
    in_bit_index <= idx;
    in_flags_in  <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(op, a, b, idx, fin);
    requests_sent++;
  endtask

  // Holds off new requests until every outstanding result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: stall for a random number of cycles, then take one result.
  initial begin
    int w;
    forever begin
      w = draw_wait();
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Every result taken is checked against the oldest expected outcome.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      sb.check_result(out_result, out_flags_out);
    end
  end

  initial begin
    logic [4:0] op;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: carries, borrows, zero results and the pass-through
    // cases of compare, bit test, set and complement carry and unused codes.
    drive_request(OP_ADD,  8'hFF, 8'h01, 3'd0, 8'h00);
    drive_request(OP_ADD,  8'h0F, 8'h01, 3'd0, 8'hF0);
    drive_request(OP_ADC,  8'hFF, 8'h00, 3'd0, 8'h10);
    drive_request(OP_ADC,  8'h00, 8'h00, 3'd0, 8'h0F);
    drive_request(OP_SUB,  8'h00, 8'h01, 3'd0, 8'h00);
    drive_request(OP_SUB,  8'h80, 8'h80, 3'd0, 8'hFF);
    drive_request(OP_SBC,  8'h10, 8'h0F, 3'd0, 8'h10);
    drive_request(OP_AND,  8'hF0, 8'h0F, 3'd0, 8'hF0);
    drive_request(OP_XOR,  8'hFF, 8'hFF, 3'd0, 8'h00);
    drive_request(OP_OR,   8'h00, 8'h00, 3'd0, 8'hFF);
    drive_request(OP_CP,   8'h3C, 8'h3C, 3'd0, 8'h00);
    drive_request(OP_INC,  8'h00, 8'hFF, 3'd0, 8'h10);
    drive_request(OP_DEC,  8'h00, 8'h00, 3'd0, 8'h00);
    drive_request(OP_RLCA, 8'h80, 8'h00, 3'd0, 8'h80);
    drive_request(OP_RLA,  8'h80, 8'h00, 3'd0, 8'h10);
    drive_request(OP_RRCA, 8'h01, 8'h00, 3'd0, 8'h00);
    drive_request(OP_RRA,  8'h01, 8'h00, 3'd0, 8'h00);
    drive_request(OP_RLC,  8'h00, 8'h00, 3'd0, 8'h10);
    drive_request(OP_RL,   8'h00, 8'h80, 3'd0, 8'h00);
    drive_request(OP_RRC,  8'h00, 8'h01, 3'd0, 8'h00);
    drive_request(OP_RR,   8'h00, 8'h00, 3'd0, 8'h10);
    drive_request(OP_BIT,  8'h00, 8'h7F, 3'd7, 8'h10);
    drive_request(OP_CPL,  8'h5A, 8'h00, 3'd0, 8'h90);
    drive_request(OP_SCF,  8'hA5, 8'h00, 3'd0, 8'h60);
    drive_request(OP_CCF,  8'hA5, 8'h00, 3'd0, 8'hF0);
    drive_request(5'd31,   8'hC3, 8'h00, 3'd0, 8'hFF);

    // Let everything come back before the random part begins.
    drain_results();

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_REQUESTS / 2) drain_results();
      if ($urandom_range(0, 9) == 0) op = 5'($urandom_range(22, 31));
      else op = 5'($urandom_range(0, 21));
      drive_request(op, pick_byte(), pick_byte(), 3'($urandom_range(0, 7)),
                    8'($urandom_range(0, 255)));
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Sent %0d requests covering every operation and unused codes,", requests_sent);
    $display("with random gaps and stalls on both sides; %0d results checked.", sb.checked);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/c8alu_pkg.sv
rtl/c8alu_decode.sv
rtl/c8alu_exec.sv
rtl/c8alu_flags.sv
rtl/cpu8_alu_with_flags_top.sv
rtl/c8alu_checker.sv
bench/tb_cpu8_alu_with_flags_top.sv
